@@ sv/pgm_pkg.sv @@
// ----------------------------------------------------------------------------
// pgm_pkg
// Shared types and constants of the pyramid gradient block.
// ----------------------------------------------------------------------------
package pgm_pkg;

  localparam int unsigned PIX_W     = 16;
  localparam int unsigned INT_W     = 22;
  localparam int unsigned MSK_W     = 8;
  localparam int unsigned GRAD_W    = 23;
  localparam int unsigned SQ_W      = 45;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned LVL_W     = 2;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FRAC_SH   = 6;
  localparam int unsigned PIX_BITS  = INT_W + MSK_W;
  localparam logic [MSK_W-1:0] MASK_VALID = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_LEVELS_USED,
    CFG_MASK_ENABLE
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [MSK_W-1:0] mask_in;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0]         level;
    logic [POS_W-1:0]         col;
    logic [POS_W-1:0]         row;
    logic [INT_W-1:0]         intensity;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [SQ_W-1:0]          grad_sq;
    logic [MSK_W-1:0]         mask_level;
    logic                     last;
  } out_item_t;

  // level pixel, same layout as one row slot of a line memory entry
  typedef struct packed {
    logic [MSK_W-1:0] mask;
    logic [INT_W-1:0] intensity;
  } lvl_pix_t;

  typedef struct packed {
    logic [LVL_W-1:0]         level;
    logic [POS_W-1:0]         col;
    logic [POS_W-1:0]         row;
    logic [INT_W-1:0]         intensity;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [MSK_W-1:0]         mask_level;
  } lvl_res_t;

endpackage

@@ sv/pgm_stream_if.sv @@
// ----------------------------------------------------------------------------
// pgm_stream_if
// Valid/ready stream channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface pgm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/pgm_ram.sv @@
// ----------------------------------------------------------------------------
// pgm_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module pgm_ram #(
  parameter int unsigned WIDTH = 60,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

@@ sv/pgm_level.sv @@
// ----------------------------------------------------------------------------
// pgm_level
// One pyramid level: position counter, two-row line memory, gradient and
// 2x2 average for the next level.
// ----------------------------------------------------------------------------
module pgm_level import pgm_pkg::*; #(
  parameter int unsigned LVL        = 0,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned CW         = $clog2(MAX_WIDTH),
  parameter int unsigned RW         = $clog2(MAX_HEIGHT),
  parameter int unsigned WLW        = $clog2(MAX_WIDTH + 1),
  parameter int unsigned HLW        = $clog2(MAX_HEIGHT + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           restart_i,
  input  logic [WLW-1:0] wl_i,
  input  logic [HLW-1:0] hl_i,
  input  logic           go_down_i,
  input  logic           in_step_i,
  input  logic           in_pv_i,
  input  lvl_pix_t       in_pix_i,
  output logic           out_step_o,
  output logic           out_pv_o,
  output lvl_pix_t       out_pix_o,
  output logic           res_v_o,
  output lvl_res_t       res_o
);

  localparam int unsigned DEPTH_RAW = MAX_WIDTH >> LVL;
  localparam int unsigned DEPTH     = (DEPTH_RAW > 0) ? DEPTH_RAW : 1;
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ENT_W     = 2 * PIX_BITS;

  logic [CW-1:0]  cnt_col_q, cnt_col_d;
  logic [RW-1:0]  cnt_row_q, cnt_row_d;
  logic [WLW-1:0] col_nxt;
  logic [HLW-1:0] row_nxt;

  logic           r_step_q, r_pv_q;
  lvl_pix_t       r_pix_q;
  logic [CW-1:0]  r_col_q, r_col_p1;
  logic [RW-1:0]  r_row_q;

  logic           c_step_q, c_pv_q;
  lvl_pix_t       c_pix_q;
  logic [CW-1:0]  c_col_q;
  logic [RW-1:0]  c_row_q;

  logic             fwd0_q, fwd1_q;
  logic [ENT_W-1:0] wd_q;
  logic [ENT_W-1:0] rd0, rd1, ent0, ent1, wdata;
  logic             we;
  logic [AW-1:0]    waddr, raddr0, raddr1;

  lvl_pix_t prev_a_q, prev_cur_q, row_start_q, last_a_q;
  lvl_pix_t row_a, row_b, right_a, lft, rgt;
  logic     c_last;
  logic [INT_W+1:0] sum_int;
  logic [MSK_W+1:0] sum_msk;

  // position counter of the next pixel at this level
  always_comb begin
    cnt_col_d = cnt_col_q;
    cnt_row_d = cnt_row_q;
    col_nxt   = WLW'(cnt_col_q) + WLW'(1);
    row_nxt   = HLW'(cnt_row_q) + HLW'(1);
    if (col_nxt >= wl_i) begin
      cnt_col_d = '0;
      if (row_nxt >= hl_i) begin
        cnt_row_d = '0;
      end else begin
        cnt_row_d = RW'(row_nxt);
      end
    end else begin
      cnt_col_d = CW'(col_nxt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_col_q <= '0;
      cnt_row_q <= '0;
      r_step_q  <= 1'b0;
      r_pv_q    <= 1'b0;
      c_step_q  <= 1'b0;
      c_pv_q    <= 1'b0;
      fwd0_q    <= 1'b0;
      fwd1_q    <= 1'b0;
    end else if (restart_i) begin
      cnt_col_q <= '0;
      cnt_row_q <= '0;
    end else if (adv_i) begin
      r_step_q <= in_step_i;
      r_pv_q   <= in_pv_i;
      c_step_q <= r_step_q;
      c_pv_q   <= r_pv_q;
      fwd0_q   <= we && (waddr == raddr0);
      fwd1_q   <= we && (waddr == raddr1);
      if (in_pv_i) begin
        cnt_col_q <= cnt_col_d;
        cnt_row_q <= cnt_row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      wd_q <= wdata;
      if (in_pv_i) begin
        r_pix_q <= in_pix_i;
        r_col_q <= cnt_col_q;
        r_row_q <= cnt_row_q;
      end
      c_pix_q <= r_pix_q;
      c_col_q <= r_col_q;
      c_row_q <= r_row_q;
      if (c_pv_q) begin
        prev_a_q   <= row_a;
        prev_cur_q <= c_pix_q;
        if (c_col_q == '0) begin
          row_start_q <= c_pix_q;
        end
        if (c_last) begin
          last_a_q <= row_a;
        end
      end
    end
  end

  // entry: upper half row r-2, lower half row r-1 (before this pixel's write)
  assign r_col_p1 = r_col_q + CW'(1);
  assign raddr0   = r_col_q[AW-1:0];
  assign raddr1   = r_col_p1[AW-1:0];
  assign we       = adv_i && c_pv_q;
  assign waddr    = c_col_q[AW-1:0];
  assign wdata    = {ent0[PIX_BITS-1:0], c_pix_q};

  pgm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .re_i     (adv_i),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  assign ent0    = fwd0_q ? wd_q : rd0;
  assign ent1    = fwd1_q ? wd_q : rd1;
  assign row_a   = lvl_pix_t'(ent0[PIX_BITS-1:0]);
  assign row_b   = lvl_pix_t'(ent0[ENT_W-1:PIX_BITS]);
  assign right_a = lvl_pix_t'(ent1[PIX_BITS-1:0]);
  assign c_last  = (WLW'(c_col_q) + WLW'(1)) >= wl_i;

  // edge columns wrap into the neighboring rows
  assign lft = (c_col_q != '0) ? prev_a_q : last_a_q;
  always_comb begin
    if (!c_last) begin
      rgt = right_a;
    end else if (c_col_q == '0) begin
      rgt = c_pix_q;
    end else begin
      rgt = row_start_q;
    end
  end

  assign res_v_o          = c_pv_q && (c_row_q >= RW'(2));
  assign res_o.level      = LVL_W'(LVL);
  assign res_o.col        = POS_W'(c_col_q);
  assign res_o.row        = POS_W'(c_row_q - RW'(1));
  assign res_o.intensity  = row_a.intensity;
  assign res_o.mask_level = row_a.mask;
  assign res_o.grad_x     = $signed({1'b0, rgt.intensity}) - $signed({1'b0, lft.intensity});
  assign res_o.grad_y     = $signed({1'b0, c_pix_q.intensity})
                          - $signed({1'b0, row_b.intensity});

  // 2x2 average feeding the next level
  assign sum_int = (INT_W+2)'(prev_a_q.intensity) + (INT_W+2)'(row_a.intensity)
                 + (INT_W+2)'(prev_cur_q.intensity) + (INT_W+2)'(c_pix_q.intensity);
  assign sum_msk = (MSK_W+2)'(prev_a_q.mask) + (MSK_W+2)'(row_a.mask)
                 + (MSK_W+2)'(prev_cur_q.mask) + (MSK_W+2)'(c_pix_q.mask);

  assign out_step_o          = c_step_q;
  assign out_pv_o            = c_pv_q && go_down_i && c_col_q[0] && c_row_q[0];
  assign out_pix_o.intensity = sum_int[INT_W+1:2];
  assign out_pix_o.mask      = sum_msk[MSK_W+1:2];

endmodule

@@ sv/pgm_out.sv @@
// ----------------------------------------------------------------------------
// pgm_out
// Holds the results of one item, squares the gradients and hands the
// results out one per cycle while the output port is ready; owns the stall of the level pipeline.
// ----------------------------------------------------------------------------
module pgm_out import pgm_pkg::*; #(
  parameter int unsigned LEVELS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [LEVELS-1:0] v_i,
  input  lvl_res_t          res_i [LEVELS],
  input  logic              mask_enable_i,
  output logic              adv_o,
  pgm_stream_if.source      out_if
);

  localparam int unsigned SEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic [LEVELS-1:0] rem_q, low, rest;
  lvl_res_t          f_res_q [LEVELS];
  lvl_res_t          sel_res;
  logic [SEL_W-1:0]  sel;
  logic              busy, out_adv, pop;
  logic signed [2*GRAD_W-1:0] px, py;

  logic            m_v_q, m_last_q;
  lvl_res_t        m_res_q;
  logic [SQ_W-1:0] m_sqx_q, m_sqy_q;

  logic      o_v_q;
  out_item_t o_item_q;

  assign low  = rem_q & (~rem_q + LEVELS'(1));
  assign rest = rem_q & ~low;

  always_comb begin
    sel = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        sel = SEL_W'(i);
      end
    end
  end

  assign sel_res = f_res_q[sel];
  assign busy    = |rem_q;
  assign out_adv = !o_v_q || out_if.ready;
  assign pop     = busy && out_adv;
  assign adv_o   = !busy || (pop && (rest == '0));
  assign px      = sel_res.grad_x * sel_res.grad_x;
  assign py      = sel_res.grad_y * sel_res.grad_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      m_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (adv_o) begin
        rem_q <= step_i ? v_i : '0;
      end else if (pop) begin
        rem_q <= rest;
      end
      if (out_adv) begin
        m_v_q <= pop;
        o_v_q <= m_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      f_res_q <= res_i;
    end
    if (out_adv) begin
      m_res_q             <= sel_res;
      m_last_q            <= (rest == '0);
      m_sqx_q             <= px[SQ_W-1:0];
      m_sqy_q             <= py[SQ_W-1:0];
      o_item_q.level      <= m_res_q.level;
      o_item_q.col        <= m_res_q.col;
      o_item_q.row        <= m_res_q.row;
      o_item_q.intensity  <= m_res_q.intensity;
      o_item_q.grad_x     <= m_res_q.grad_x;
      o_item_q.grad_y     <= m_res_q.grad_y;
      o_item_q.mask_level <= m_res_q.mask_level;
      o_item_q.last       <= m_last_q;
      if (mask_enable_i && (m_res_q.mask_level != MASK_VALID)) begin
        o_item_q.grad_sq <= '0;
      end else begin
        o_item_q.grad_sq <= m_sqx_q + m_sqy_q;
      end
    end
  end

  assign out_if.valid   = o_v_q;
  assign out_if.payload = o_item_q;

endmodule

@@ sv/pyramid_gradient_with_mask.sv @@
// ----------------------------------------------------------------------------
// pyramid_gradient_with_mask
// Streaming image pyramid with masked central-difference gradients.
// ----------------------------------------------------------------------------
// Takes one level-0 pixel per cycle when not stalled and carries it through
// one stage pair per level (line memory read, then gradient, write-back and
// 2x2 average for the next level); each level keeps its last two rows in its
// own line RAM, indexed by column. Results of one item leave together, lowest
// level first, and the output port hands out one result per cycle while it is
// ready: an item with several results holds the input until its last result
// is popped, so the input runs at one item per cycle, output permitting,
// wherever an item completes at most one result. No clearing pass after reset
// is needed. Any configuration write restarts the frame.
module pyramid_gradient_with_mask import pgm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned LEVELS     = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  pgm_stream_if.sink           in_if,
  pgm_stream_if.source         out_if
);

  localparam int unsigned WLW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HLW = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [2:0]       levels_used_q, nlev;
  logic             mask_enable_q;

  logic [WLW-1:0] w0;
  logic [HLW-1:0] h0;
  logic [WLW-1:0] lv_wl [LEVELS];
  logic [HLW-1:0] lv_hl [LEVELS];

  logic              adv;
  logic [LEVELS-1:0] lv_step, lv_pv, lv_go, res_v, g_v;
  lvl_pix_t          lv_pix [LEVELS];
  lvl_res_t          lv_res [LEVELS];
  lvl_res_t          g_res  [LEVELS];
  lvl_pix_t          pix0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CFG_W'(640);
      frame_height_q <= CFG_W'(480);
      levels_used_q  <= 3'd4;
      mask_enable_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_LEVELS_USED:  levels_used_q  <= cfg_data_i[2:0];
        CFG_MASK_ENABLE:  mask_enable_q  <= cfg_data_i[0];
      endcase
    end
  end

  always_comb begin
    if (frame_width_q == '0) begin
      w0 = WLW'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w0 = WLW'(MAX_WIDTH);
    end else begin
      w0 = WLW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      h0 = HLW'(1);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      h0 = HLW'(MAX_HEIGHT);
    end else begin
      h0 = HLW'(frame_height_q);
    end
    if (levels_used_q == '0) begin
      nlev = 3'd1;
    end else if (32'(levels_used_q) > LEVELS) begin
      nlev = 3'(LEVELS);
    end else begin
      nlev = levels_used_q;
    end
  end

  assign pix0.intensity = INT_W'(in_if.payload.pixel_value) << FRAC_SH;
  assign pix0.mask      = in_if.payload.mask_in;
  assign in_if.ready    = adv;

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int unsigned D = 2 * (LEVELS - 1 - l);

    assign lv_wl[l] = w0 >> l;
    assign lv_hl[l] = h0 >> l;
    assign lv_go[l] = (l + 1) < 32'(nlev);

    if (l == 0) begin : g_first
      pgm_level #(
        .LVL        (l),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
      ) u_level (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .adv_i      (adv),
        .restart_i  (cfg_we_i),
        .wl_i       (lv_wl[l]),
        .hl_i       (lv_hl[l]),
        .go_down_i  (lv_go[l]),
        .in_step_i  (in_if.valid),
        .in_pv_i    (in_if.valid),
        .in_pix_i   (pix0),
        .out_step_o (lv_step[l]),
        .out_pv_o   (lv_pv[l]),
        .out_pix_o  (lv_pix[l]),
        .res_v_o    (res_v[l]),
        .res_o      (lv_res[l])
      );
    end else begin : g_next
      pgm_level #(
        .LVL        (l),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
      ) u_level (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .adv_i      (adv),
        .restart_i  (cfg_we_i),
        .wl_i       (lv_wl[l]),
        .hl_i       (lv_hl[l]),
        .go_down_i  (lv_go[l]),
        .in_step_i  (lv_step[l-1]),
        .in_pv_i    (lv_pv[l-1]),
        .in_pix_i   (lv_pix[l-1]),
        .out_step_o (lv_step[l]),
        .out_pv_o   (lv_pv[l]),
        .out_pix_o  (lv_pix[l]),
        .res_v_o    (res_v[l]),
        .res_o      (lv_res[l])
      );
    end

    // align each level's result with the item at the last level
    if (D == 0) begin : g_nodly
      assign g_v[l]   = res_v[l];
      assign g_res[l] = lv_res[l];
    end else begin : g_dly
      logic     dly_v_q   [D];
      lvl_res_t dly_res_q [D];

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          for (int k = 0; k < D; k++) begin
            dly_v_q[k] <= 1'b0;
          end
        end else if (adv) begin
          dly_v_q[0] <= res_v[l];
          for (int k = 1; k < D; k++) begin
            dly_v_q[k] <= dly_v_q[k-1];
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv) begin
          dly_res_q[0] <= lv_res[l];
          for (int k = 1; k < D; k++) begin
            dly_res_q[k] <= dly_res_q[k-1];
          end
        end
      end

      assign g_v[l]   = dly_v_q[D-1];
      assign g_res[l] = dly_res_q[D-1];
    end
  end

  pgm_out #(
    .LEVELS (LEVELS)
  ) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (lv_step[LEVELS-1]),
    .v_i           (g_v),
    .res_i         (g_res),
    .mask_enable_i (mask_enable_q),
    .adv_o         (adv),
    .out_if        (out_if)
  );

  a_pix_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lv_pv & ~lv_step) == '0)
    else $error("level pixel outside an item slot");

  a_lvl0_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v[0] |-> (lv_res[0].row != '0) && (lv_res[0].level == '0))
    else $error("level 0 result on a border row");

  a_mask_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && mask_enable_q && (out_if.payload.mask_level != MASK_VALID)
    |-> out_if.payload.grad_sq == '0)
    else $error("masked result with nonzero squared gradient");

endmodule
